FILE: hw/rtl/pstf_pkg.sv
// Shared types, constants and register codes of the PNM sample text formatter.
package pstf_pkg;

    // Samples per text line unless overridden at the top level
    localparam int SAMPLES_PER_LINE_DEF = 20;
    // Width of the line counter (covers up to 32 samples per line)
    localparam int CNT_W = 5;
    // Most bytes that one sample can produce
    localparam int MAX_BYTES = 7;
    localparam int BUF_CNT_W = $clog2(MAX_BYTES + 1);
    // Register address width: two 32-bit registers
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Characters
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Register indexes
    typedef enum logic {
        REG_ASCII_MODE   = 1'b0,
        REG_WIDE_SAMPLES = 1'b1
    } t_reg_idx;

    // Input word
    typedef struct packed {
        logic [15:0] sample;
        logic        frame_start;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_word;

    // Configuration register set
    typedef struct packed {
        logic ascii_mode;
        logic wide_samples;
    } t_cfg;

    // Sample split by 100, handed from the divider to the formatter
    typedef struct packed {
        logic [15:0] s;
        logic [9:0]  q;
        logic [6:0]  r;
        logic        nl;
    } t_dec_word;

endpackage

FILE: hw/rtl/pstf_cfg.sv
// APB register file holding the output mode and sample width.
module pstf_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pstf_pkg::ADDR_W-1:0]  paddr,
    input  logic [pstf_pkg::DATA_W-1:0]  pwdata,
    output logic [pstf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output pstf_pkg::t_cfg               o_cfg
);

    pstf_pkg::t_cfg r_cfg;
    pstf_pkg::t_reg_idx reg_idx;

    assign reg_idx = pstf_pkg::t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write a register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                pstf_pkg::REG_ASCII_MODE:   r_cfg.ascii_mode   <= pwdata[0];
                pstf_pkg::REG_WIDE_SAMPLES: r_cfg.wide_samples <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (reg_idx)
            pstf_pkg::REG_ASCII_MODE:   prdata[0] = r_cfg.ascii_mode;
            pstf_pkg::REG_WIDE_SAMPLES: prdata[0] = r_cfg.wide_samples;
            default:                    prdata    = '0;
        endcase
    end

endmodule

FILE: hw/rtl/pstf_conv.sv
// Input register, line counter and divide-by-100 stage.
module pstf_conv #(
    parameter int SAMPLES_PER_LINE = pstf_pkg::SAMPLES_PER_LINE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pstf_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pstf_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pstf_pkg::t_dec_word  o_dec
);

    localparam logic [pstf_pkg::CNT_W:0] SPL = (pstf_pkg::CNT_W + 1)'(SAMPLES_PER_LINE);
    // ceil(2^19 / 100): estimate is exact or one too high over 16 bits
    localparam logic [28:0] RECIP = 29'd5243;

    logic                        r_s1_v;
    logic [15:0]                 r_s1_s;
    logic                        r_s1_nl;
    logic                        r_s2_v;
    pstf_pkg::t_dec_word         r_s2;
    logic [pstf_pkg::CNT_W-1:0]  r_count;

    logic                        accept;
    logic                        s2_free;
    logic [pstf_pkg::CNT_W-1:0]  cnt_base;
    logic [pstf_pkg::CNT_W:0]    cnt_inc;
    logic                        nl;
    logic [pstf_pkg::CNT_W-1:0]  n_count;
    logic [15:0]                 s_masked;
    logic [28:0]                 prod;
    logic [9:0]                  q_est;
    logic [16:0]                 p_est;
    logic [16:0]                 rem_est;
    logic                        over;
    pstf_pkg::t_dec_word         n_s2;

    assign s2_free = !r_s2_v || i_ready;
    assign o_ready = !r_s1_v || s2_free;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_s2_v;
    assign o_dec   = r_s2;

    // Advance the line counter; wrap with a newline at the line length
    always_comb begin
        cnt_base = i_data.frame_start ? '0 : r_count;
        cnt_inc  = {1'b0, cnt_base} + 1'b1;
        nl       = (cnt_inc >= SPL);
        n_count  = nl ? '0 : cnt_inc[pstf_pkg::CNT_W-1:0];
        s_masked = i_cfg.wide_samples ? i_data.sample : {8'h00, i_data.sample[7:0]};
    end

    // Split the sample into quotient and remainder by 100
    always_comb begin
        prod    = 29'(r_s1_s) * RECIP;
        q_est   = prod[28:19];
        p_est   = {1'b0, q_est, 6'b0} + {2'b0, q_est, 5'b0} + {5'b0, q_est, 2'b0};
        over    = p_est > {1'b0, r_s1_s};
        rem_est = {1'b0, r_s1_s} - p_est;
        n_s2.s  = r_s1_s;
        n_s2.nl = r_s1_nl;
        n_s2.q  = over ? q_est - 10'd1 : q_est;
        n_s2.r  = over ? 7'(rem_est + 17'd100) : rem_est[6:0];
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_count <= '0;
        end else begin
            if (o_ready) begin
                r_s1_v <= i_valid;
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_s  <= s_masked;
            r_s1_nl <= nl;
        end
        if (s2_free && r_s1_v) begin
            r_s2 <= n_s2;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < SPL)
        else $error("line counter out of range");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_data.frame_start |=> r_count <= pstf_pkg::CNT_W'(1))
        else $error("frame start did not restart the line");

    a_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_s2.r < 7'd100) && (r_s2.q < 10'd656))
        else $error("divide by 100 out of range");

endmodule

FILE: hw/rtl/pstf_fmt.sv
// Digit extraction, byte assembly and a byte buffer sending one byte per cycle while i_ready is high.
module pstf_fmt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pstf_pkg::t_cfg       i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pstf_pkg::t_dec_word  i_dec,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pstf_pkg::t_out_word  o_data
);

    localparam int MB = pstf_pkg::MAX_BYTES;
    localparam int CW = pstf_pkg::BUF_CNT_W;

    localparam logic [1:0] MODE_RAW_NARROW   = 2'b00;
    localparam logic [1:0] MODE_RAW_WIDE     = 2'b01;
    localparam logic [1:0] MODE_TEXT_NARROW  = 2'b10;
    localparam logic [1:0] MODE_TEXT_WIDE    = 2'b11;

    logic [CW-1:0] r_cnt;
    logic [7:0]    r_bytes [MB];

    logic [7:0]    n_bytes [MB];
    logic [CW-1:0] n_cnt;
    logic          load;
    logic          take;
    logic [3:0]    d4, d3, d2, d1, d0;
    logic [6:0]    hq;
    logic          blank4, blank3, blank2, blank1;
    logic [7:0]    c4, c3, c2, c1, c0;

    // Tens digit of a value below 100
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    // Ones digit of a value below 100
    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [6:0] t;
        t = 7'(tens_of(v)) * 7'd10;
        return 4'(v - t);
    endfunction

    function automatic logic [7:0] to_char(input logic [3:0] d, input logic blank);
        return blank ? pstf_pkg::CHAR_SPACE : pstf_pkg::CHAR_ZERO + {4'b0, d};
    endfunction

    assign take    = (r_cnt != '0) && i_ready;
    assign o_ready = (r_cnt == '0) || ((r_cnt == CW'(1)) && i_ready);
    assign load    = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data.out_byte  = r_bytes[0];
    assign o_data.last_byte = (r_cnt == CW'(1));

    // Extract the five decimal digits and blank leading zeros
    always_comb begin
        if (i_dec.q >= 10'd600)      d4 = 4'd6;
        else if (i_dec.q >= 10'd500) d4 = 4'd5;
        else if (i_dec.q >= 10'd400) d4 = 4'd4;
        else if (i_dec.q >= 10'd300) d4 = 4'd3;
        else if (i_dec.q >= 10'd200) d4 = 4'd2;
        else if (i_dec.q >= 10'd100) d4 = 4'd1;
        else                         d4 = 4'd0;
        hq = 7'(i_dec.q - 10'(d4) * 10'd100);
        d3 = tens_of(hq);
        d2 = ones_of(hq);
        d1 = tens_of(i_dec.r);
        d0 = ones_of(i_dec.r);
        blank4 = (d4 == 4'd0);
        blank3 = blank4 && (d3 == 4'd0);
        blank2 = blank3 && (d2 == 4'd0);
        blank1 = blank2 && (d1 == 4'd0);
        c4 = to_char(d4, blank4);
        c3 = to_char(d3, blank3);
        c2 = to_char(d2, blank2);
        c1 = to_char(d1, blank1);
        c0 = to_char(d0, 1'b0);
    end

    // Assemble the bytes of one sample
    always_comb begin
        for (int k = 0; k < MB; k++) begin
            n_bytes[k] = pstf_pkg::CHAR_SPACE;
        end
        n_cnt = '0;
        case ({i_cfg.ascii_mode, i_cfg.wide_samples})
            MODE_TEXT_WIDE: begin
                n_bytes[0] = c4;
                n_bytes[1] = c3;
                n_bytes[2] = c2;
                n_bytes[3] = c1;
                n_bytes[4] = c0;
                n_bytes[6] = pstf_pkg::CHAR_NL;
                n_cnt      = i_dec.nl ? CW'(7) : CW'(6);
            end
            MODE_TEXT_NARROW: begin
                n_bytes[0] = c2;
                n_bytes[1] = c1;
                n_bytes[2] = c0;
                n_bytes[4] = pstf_pkg::CHAR_NL;
                n_cnt      = i_dec.nl ? CW'(5) : CW'(4);
            end
            MODE_RAW_WIDE: begin
                n_bytes[0] = i_dec.s[15:8];
                n_bytes[1] = i_dec.s[7:0];
                n_cnt      = CW'(2);
            end
            MODE_RAW_NARROW: begin
                n_bytes[0] = i_dec.s[7:0];
                n_cnt      = CW'(1);
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // Hold the byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (load) begin
            r_cnt <= n_cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Load a new sample, or shift one byte out
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= n_bytes;
        end else if (take) begin
            for (int k = 0; k < MB - 1; k++) begin
                r_bytes[k] <= r_bytes[k + 1];
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MB))
        else $error("byte count above maximum");

    a_text_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_cfg.ascii_mode |=> r_cnt >= CW'(4))
        else $error("text sample shorter than four bytes");

    a_text_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last_byte && i_cfg.ascii_mode |->
        (r_bytes[0] == pstf_pkg::CHAR_SPACE || r_bytes[0] == pstf_pkg::CHAR_NL))
        else $error("text sample does not end in a separator");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !load |=> r_cnt == $past(r_cnt) - CW'(1))
        else $error("byte count did not step down");

endmodule

FILE: hw/rtl/pnm_sample_text_formatter.sv
// Top level of the PNM sample formatter: text or raw body bytes, one per word.
// A sample passes the input register, the divide register and the byte buffer in turn.
// Throughput: one output byte per cycle while i_ready is high, set by the single-byte output port;
// a sample gives 1 (raw narrow), 2 (raw wide), 4-5 (text narrow) or 6-7 (text wide) bytes.
// A new sample is accepted every cycle in raw narrow mode while the output keeps up.
// Reset (synchronous, active low) clears both registers, the line counter and all valids.
module pnm_sample_text_formatter #(
    parameter int SAMPLES_PER_LINE = pstf_pkg::SAMPLES_PER_LINE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pstf_pkg::ADDR_W-1:0]  paddr,
    input  logic [pstf_pkg::DATA_W-1:0]  pwdata,
    output logic [pstf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  pstf_pkg::t_in_word           i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output pstf_pkg::t_out_word          o_data
);

    pstf_pkg::t_cfg      cfg;
    pstf_pkg::t_dec_word dec;
    logic                dec_valid;
    logic                dec_ready;

    pstf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pstf_conv #(
        .SAMPLES_PER_LINE (SAMPLES_PER_LINE)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_dec   (dec)
    );

    pstf_fmt u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
